FILE: src/tasp_pkg.sv
// Shared constants, register and phase codes for the two-axis slew profiler.
package tasp_pkg;

  localparam int PositionBitsDefault = 12;

  localparam int FieldBits  = 12;
  localparam int VelBits    = 11;
  localparam int AccBits    = 4;
  localparam int SettleBits = 16;
  localparam int PhaseBits  = 2;
  localparam int VelLimit   = 1023;
  // Enough signed bits for a velocity plus one acceleration step.
  localparam int VelWorkBits = 12;

  localparam int HomeDefault = 2048;
  localparam logic [AccBits-1:0]    AccelDefault  = 4'd1;
  localparam logic [SettleBits-1:0] SettleDefault = 16'd50;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;
  localparam logic [CfgIdxBits-1:0] RegAccelPan    = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegAccelTilt   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegSettleTicks = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegHomePan     = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegHomeTilt    = 3'd4;

  localparam logic [PhaseBits-1:0] PhStable   = 2'd0;
  localparam logic [PhaseBits-1:0] PhMoving   = 2'd1;
  localparam logic [PhaseBits-1:0] PhSettling = 2'd2;
  localparam logic [PhaseBits-1:0] PhUnused   = 2'd3;

  localparam int InDataBits     = 32;
  localparam int OutPayloadBits = 2 * FieldBits + 2 * VelBits + 1 + PhaseBits;
  localparam int OutDataBits    = ((OutPayloadBits + 7) / 8) * 8;

  // A zero acceleration setting acts as one.
  function automatic logic [AccBits-1:0] eff_accel(input logic [AccBits-1:0] a);
    return (a == '0) ? AccBits'(1) : a;
  endfunction

endpackage

FILE: src/tasp_lim_unit.sv
// Iterative limit-velocity search: sums a, 2a, 3a ... until the distance is covered.
module tasp_lim_unit #(
  parameter int PosBits = tasp_pkg::PositionBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [PosBits-1:0]          dist_i,
  input  logic [tasp_pkg::AccBits-1:0] accel_i,
  output logic                        done_o,
  output logic [PosBits:0]            lim_o
);
  import tasp_pkg::*;

  logic             busy_q, busy_d;
  logic [PosBits:0] lim_q, cover_q;
  logic [PosBits:0] lim_inc, cover_inc;
  logic             covered;

  // One step of the shared accumulator: lim += a, cover += lim.
  assign lim_inc   = lim_q + (PosBits + 1)'(accel_i);
  assign cover_inc = cover_q + lim_inc;
  assign covered   = cover_q >= {1'b0, dist_i};
  assign done_o    = busy_q && !start_i && covered;
  assign lim_o     = lim_q;

  always_comb begin
    busy_d = busy_q;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lim_q   <= '0;
      cover_q <= '0;
    end else if (busy_q && !covered) begin
      lim_q   <= lim_inc;
      cover_q <= cover_inc;
    end
  end

endmodule

FILE: src/tasp_axis_upd.sv
// One axis update: distance, accelerate or brake against the limit, snap and saturate.
module tasp_axis_upd #(
  parameter int PosBits = tasp_pkg::PositionBitsDefault
) (
  input  logic [PosBits-1:0]                  pos_i,
  input  logic signed [tasp_pkg::VelBits-1:0] vel_i,
  input  logic [PosBits-1:0]                  goal_i,
  input  logic [tasp_pkg::AccBits-1:0]        accel_i,
  input  logic [PosBits:0]                    lim_i,
  output logic [PosBits-1:0]                  dist_o,
  output logic [PosBits-1:0]                  pos_o,
  output logic signed [tasp_pkg::VelBits-1:0] vel_o
);
  import tasp_pkg::*;

  localparam int W = (PosBits + 2 > VelWorkBits) ? PosBits + 2 : VelWorkBits;
  localparam logic signed [W-1:0] VelMax = W'(VelLimit);
  localparam logic signed [W-1:0] PosMax = $signed(W'({PosBits{1'b1}}));

  logic signed [W-1:0] pos_s, goal_s, diff, dist_s, vel_s, nv, a_s, lim_s;
  logic signed [W-1:0] nv_step, nv_dir, nv_sat, sum;
  logic                back, snap;

  always_comb begin
    pos_s  = $signed(W'(pos_i));
    goal_s = $signed(W'(goal_i));
    vel_s  = W'(vel_i);
    a_s    = $signed(W'(accel_i));
    lim_s  = $signed(W'(lim_i));
    diff   = goal_s - pos_s;
    back   = diff[W-1];
    dist_s = back ? -diff : diff;
    nv     = back ? -vel_s : vel_s;
    snap   = (dist_s <= a_s) && (nv <= a_s) && (nv >= -a_s);

    // Speed up while below the limit, otherwise brake.
    nv_step = (nv + a_s < lim_s) ? nv + a_s : nv - a_s;
    nv_dir  = back ? -nv_step : nv_step;
    if (nv_dir > VelMax) begin
      nv_sat = VelMax;
    end else if (nv_dir < -VelMax) begin
      nv_sat = -VelMax;
    end else begin
      nv_sat = nv_dir;
    end

    sum = pos_s + nv_sat;
    if (snap) begin
      pos_o = goal_i;
      vel_o = '0;
    end else begin
      if (sum[W-1]) begin
        pos_o = '0;
      end else if (sum > PosMax) begin
        pos_o = {PosBits{1'b1}};
      end else begin
        pos_o = sum[PosBits-1:0];
      end
      vel_o = nv_sat[VelBits-1:0];
    end
    dist_o = dist_s[PosBits-1:0];
  end

endmodule

FILE: src/two_axis_slew_profile.sv
// Channel   Dir   Handshake                    Contents
// s_axis    in    s_axis_tvalid/tready         shutter_free, goal_pan, goal_tilt
// m_axis    out   m_axis_tvalid/tready         positions, velocities, stable, phase
// cfg       in    cfg_valid_i/cfg_ready_o      register index and write data
// An item with no move skips the limit search. A moving item runs it for pan, then for tilt.
// The number of limit-search iterations of an axis is about sqrt(2 * distance / accel):
// up to 90 per axis at 12 position bits.
// The single accumulator in tasp_lim_unit is shared by both axes in turn.
// Reset loads the default registers and the home positions; no clearing pass.
// A stalled result sits in the output register while the next request is taken.
// Top level of the two-axis trapezoidal slew profiler.
module two_axis_slew_profile #(
  parameter int PosBits = tasp_pkg::PositionBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] shutter_free, [12:1] goal_pan, [24:13] goal_tilt, [31:25] zero
  input  logic [tasp_pkg::InDataBits-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [11:0] pan_position, [23:12] tilt_position, [34:24] pan_velocity,
  // [45:35] tilt_velocity, [46] stable_flag, [48:47] slew_phase, [55:49] zero
  output logic [tasp_pkg::OutDataBits-1:0]   m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tasp_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [tasp_pkg::CfgDataBits-1:0]   cfg_data_i
);
  import tasp_pkg::*;

  localparam int ExtBits = PosBits + FieldBits;
  localparam logic [PosBits-1:0] HomePos = PosBits'(HomeDefault);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPan  = 2'd1;
  localparam logic [1:0] StTilt = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]            state_q, state_d;
  logic                  start_q, start_d;
  logic [PhaseBits-1:0]  phase_q, phase_d;
  logic [SettleBits-1:0] settle_q, settle_d;
  logic [PosBits-1:0]    pan_pos_q, tilt_pos_q;
  logic signed [VelBits-1:0] pan_vel_q, tilt_vel_q;
  logic [PosBits-1:0]    goal_pan_q, goal_tilt_q;
  logic [AccBits-1:0]    accel_pan_q, accel_tilt_q;
  logic [SettleBits-1:0] settle_ticks_q;
  logic                  m_valid_q, m_valid_d;
  logic [OutDataBits-1:0] m_data_q, m_data_d;

  logic                  s_accept, move, at_goal, out_load, sel_tilt;
  logic [ExtBits-1:0]    gp_ext, gt_ext, pp_ext, tp_ext;
  logic [PosBits-1:0]    gp_in, gt_in;
  logic [PosBits-1:0]    sel_pos, sel_goal, upd_pos, axis_dist;
  logic signed [VelBits-1:0] sel_vel, upd_vel;
  logic [AccBits-1:0]    sel_acc;
  logic                  lim_done;
  logic [PosBits:0]      lim;

  assign s_axis_tready = (state_q == StIdle);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Goals arrive as 12-bit fields; bring them to the internal position width.
  always_comb begin
    gp_ext  = ExtBits'(s_axis_tdata[12:1]);
    gt_ext  = ExtBits'(s_axis_tdata[24:13]);
    gp_in   = gp_ext[PosBits-1:0];
    gt_in   = gt_ext[PosBits-1:0];
    at_goal = (pan_pos_q == gp_in) && (tilt_pos_q == gt_in);
  end

  // Phase controller, evaluated on the accepted request.
  always_comb begin
    phase_d  = phase_q;
    settle_d = settle_q;
    move     = 1'b0;
    if (s_accept) begin
      case (phase_q)
        PhStable: begin
          if (s_axis_tdata[0] && !at_goal) begin
            phase_d = PhMoving;
            move    = 1'b1;
          end
        end
        PhMoving: begin
          if (!at_goal) begin
            move = 1'b1;
          end else begin
            settle_d = settle_ticks_q;
            phase_d  = PhSettling;
          end
        end
        PhSettling: begin
          if (!at_goal) begin
            settle_d = '0;
            phase_d  = PhMoving;
            move     = 1'b1;
          end else if (settle_q != '0) begin
            settle_d = settle_q - 1'b1;
          end else begin
            phase_d = PhStable;
          end
        end
        default: phase_d = PhStable;
      endcase
    end
  end

  // Sequencer: for a move, pan search then tilt search; every request then hands its result to the output register.
  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (s_accept) begin
          state_d = move ? StPan : StDone;
          start_d = move;
        end
      end
      StPan: begin
        if (lim_done) begin
          state_d = StTilt;
          start_d = 1'b1;
        end
      end
      StTilt: begin
        if (lim_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign sel_tilt = (state_q == StTilt);
  assign sel_pos  = sel_tilt ? tilt_pos_q : pan_pos_q;
  assign sel_vel  = sel_tilt ? tilt_vel_q : pan_vel_q;
  assign sel_goal = sel_tilt ? goal_tilt_q : goal_pan_q;
  assign sel_acc  = eff_accel(sel_tilt ? accel_tilt_q : accel_pan_q);

  tasp_lim_unit #(
    .PosBits(PosBits)
  ) u_lim (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .dist_i (axis_dist),
    .accel_i(sel_acc),
    .done_o (lim_done),
    .lim_o  (lim)
  );

  tasp_axis_upd #(
    .PosBits(PosBits)
  ) u_upd (
    .pos_i  (sel_pos),
    .vel_i  (sel_vel),
    .goal_i (sel_goal),
    .accel_i(sel_acc),
    .lim_i  (lim),
    .dist_o (axis_dist),
    .pos_o  (upd_pos),
    .vel_o  (upd_vel)
  );

  assign out_load = (state_q == StDone) && (!m_valid_q || m_axis_tready);

  always_comb begin
    pp_ext    = ExtBits'(pan_pos_q);
    tp_ext    = ExtBits'(tilt_pos_q);
    m_data_d  = OutDataBits'({phase_q, (phase_q == PhStable), tilt_vel_q, pan_vel_q,
                              tp_ext[FieldBits-1:0], pp_ext[FieldBits-1:0]});
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      start_q        <= 1'b0;
      phase_q        <= PhStable;
      settle_q       <= '0;
      pan_pos_q      <= HomePos;
      tilt_pos_q     <= HomePos;
      pan_vel_q      <= '0;
      tilt_vel_q     <= '0;
      accel_pan_q    <= AccelDefault;
      accel_tilt_q   <= AccelDefault;
      settle_ticks_q <= SettleDefault;
      m_valid_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      start_q   <= start_d;
      phase_q   <= phase_d;
      settle_q  <= settle_d;
      m_valid_q <= m_valid_d;
      if (lim_done && !sel_tilt) begin
        pan_pos_q <= upd_pos;
        pan_vel_q <= upd_vel;
      end
      if (lim_done && sel_tilt) begin
        tilt_pos_q <= upd_pos;
        tilt_vel_q <= upd_vel;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegAccelPan:    accel_pan_q    <= cfg_data_i[AccBits-1:0];
          RegAccelTilt:   accel_tilt_q   <= cfg_data_i[AccBits-1:0];
          RegSettleTicks: settle_ticks_q <= cfg_data_i;
          // Home positions matter only at reset, which restores the defaults.
          RegHomePan, RegHomeTilt: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      goal_pan_q  <= gp_in;
      goal_tilt_q <= gt_in;
    end
    if (out_load) begin
      m_data_q <= m_data_d;
    end
  end

endmodule

FILE: src/tasp_chk.sv
// Port-level checker for the two-axis slew profiler, bound to the top level.
module tasp_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tasp_pkg::OutDataBits-1:0] m_axis_tdata
);
  import tasp_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  a_stable_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[46] == (m_axis_tdata[48:47] == PhStable))
    else $error("stable flag disagrees with phase");

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[48:47] != PhUnused)
    else $error("unused phase code reported");

endmodule

bind two_axis_slew_profile tasp_chk u_tasp_chk (.*);

FILE: verif/tb_two_axis_slew_profile.sv
// Testbench for the two-axis slew profiler: servo ticks checked against an in-bench profile model.
`timescale 1ns / 100ps
module tb_two_axis_slew_profile;
  import tasp_pkg::*;

  localparam int ClkHalf    = 10;
  localparam int CycleLimit = 2_000_000;
  localparam int DrainWait  = 250;
  localparam int HoldCycles = 1500;
  localparam int PosMax     = (1 << FieldBits) - 1;
  localparam int MaxPrinted = 40;

  // Packed from the top down, so pan_position lands in the lowest bits.
  typedef struct packed {
    logic [PhaseBits-1:0] phase;
    logic                 stable;
    logic [VelBits-1:0]   tilt_vel;
    logic [VelBits-1:0]   pan_vel;
    logic [FieldBits-1:0] tilt_pos;
    logic [FieldBits-1:0] pan_pos;
  } slew_out_t;

  typedef struct packed {
    int pos;
    int vel;
  } axis_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i   = '0;
  logic [CfgDataBits-1:0] cfg_data_i    = '0;

  two_axis_slew_profile DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Profile state and register copies
  logic [PhaseBits-1:0] pred_phase;
  int                   pred_settle;
  axis_t                pred_pan;
  axis_t                pred_tilt;
  int                   reg_accel_pan;
  int                   reg_accel_tilt;
  int                   reg_settle;
  int                   reg_home_pan;
  int                   reg_home_tilt;

  slew_out_t expected_slews[$];
  slew_out_t seen_slew;
  slew_out_t due_slew;

  int tx_max_gap   = 8;
  int rx_max_stall = 8;
  int rx_hold      = 0;

  int cycle_count     = 0;
  int mismatches      = 0;
  int results_checked = 0;
  int ticks_accepted  = 0;
  int regs_written    = 0;

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", CycleLimit,
               expected_slews.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic axis_t profile_axis(input axis_t cur, input int goal, input int acc);
    axis_t nxt;
    int    a;
    int    span;
    int    nv;
    int    lim;
    int    reach;
    bit    back;
    a     = (acc == 0) ? 1 : acc;
    span  = goal - cur.pos;
    nv    = cur.vel;
    back  = 1'b0;
    lim   = 0;
    reach = 0;
    // work in the direction of travel
    if (span < 0) begin
      back = 1'b1;
      span = -span;
      nv   = -nv;
    end
    while (reach < span) begin
      lim   += a;
      reach += lim;
    end
    if (span <= a && nv <= a && nv >= -a) begin
      nxt.pos = goal;
      nxt.vel = 0;
    end else begin
      if (nv + a < lim) nv += a;
      else nv -= a;
      if (back) nv = -nv;
      if (nv > VelLimit) nv = VelLimit;
      else if (nv < -VelLimit) nv = -VelLimit;
      nxt.vel = nv;
      nxt.pos = cur.pos + nv;
      if (nxt.pos < 0) nxt.pos = 0;
      else if (nxt.pos > PosMax) nxt.pos = PosMax;
    end
    return nxt;
  endfunction

  function automatic slew_out_t slew_tick(input logic idle, input int gp, input int gt);
    logic      at_goal;
    logic      move;
    slew_out_t res;
    at_goal = (pred_pan.pos == gp) && (pred_tilt.pos == gt);
    move    = 1'b0;
    case (pred_phase)
      PhStable: begin
        if (idle && !at_goal) begin
          pred_phase = PhMoving;
          move       = 1'b1;
        end
      end
      PhMoving: begin
        if (!at_goal) begin
          move = 1'b1;
        end else begin
          pred_settle = reg_settle;
          pred_phase  = PhSettling;
        end
      end
      PhSettling: begin
        if (!at_goal) begin
          pred_settle = 0;
          pred_phase  = PhMoving;
          move        = 1'b1;
        end else if (pred_settle > 0) begin
          pred_settle--;
        end else begin
          pred_phase = PhStable;
        end
      end
      default: pred_phase = PhStable;
    endcase
    if (move) begin
      pred_pan  = profile_axis(pred_pan, gp, reg_accel_pan);
      pred_tilt = profile_axis(pred_tilt, gt, reg_accel_tilt);
    end
    res.pan_pos  = pred_pan.pos[FieldBits-1:0];
    res.tilt_pos = pred_tilt.pos[FieldBits-1:0];
    res.pan_vel  = pred_pan.vel[VelBits-1:0];
    res.tilt_vel = pred_tilt.vel[VelBits-1:0];
    res.stable   = (pred_phase == PhStable);
    res.phase    = pred_phase;
    return res;
  endfunction

  function automatic int clamp_pos(input int v);
    if (v < 0) return 0;
    if (v > PosMax) return PosMax;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic send_tick(input logic idle, input int gp, input int gt);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, gt[FieldBits-1:0], gp[FieldBits-1:0], idle};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_slews.push_back(slew_tick(idle, gp, gt));
    ticks_accepted++;
  endtask

  // Stop offering and hold until every outstanding result is back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_slews.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CfgDataBits-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegAccelPan:    reg_accel_pan  = value & 'hF;
      RegAccelTilt:   reg_accel_tilt = value & 'hF;
      RegSettleTicks: reg_settle     = value & 'hFFFF;
      RegHomePan:     reg_home_pan   = value & 'hFFF;
      RegHomeTilt:    reg_home_tilt  = value & 'hFFF;
      default: ;
    endcase
    regs_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_profile(input int acc_pan, input int acc_tilt, input int settle);
    write_reg(RegAccelPan, acc_pan);
    write_reg(RegAccelTilt, acc_tilt);
    write_reg(RegSettleTicks, settle);
  endtask

  task automatic test_directed_phases();
    send_tick(1'b0, 0, PosMax);                           // shutter busy: stay stable
    send_tick(1'b1, HomeDefault, HomeDefault);            // already at goal
    send_tick(1'b1, HomeDefault + 1, HomeDefault - 1);    // one step away: snap
    send_tick(1'b1, HomeDefault + 1, HomeDefault - 1);    // arrive: start settling
    send_tick(1'b0, HomeDefault + 1, HomeDefault - 1);
    send_tick(1'b1, HomeDefault + 40, HomeDefault - 1);   // goal moves while settling
    repeat (3) send_tick(1'b1, 0, PosMax);
    send_tick(1'b1, PosMax, 0);                           // reverse under speed
    send_tick(1'b1, pred_pan.pos, pred_tilt.pos);         // goal at current spot, still moving
    send_tick(1'b1, 0, PosMax);
    drain_results();
    // zero settle, zero and full acceleration
    set_profile(0, 15, 0);
    repeat (3) send_tick(1'b1, pred_pan.pos, pred_tilt.pos);
    repeat (4) send_tick(1'b1, 100, 3000);
    drain_results();
    // home writes must not move anything
    write_reg(RegHomePan, 0);
    write_reg(RegHomeTilt, PosMax);
    send_tick(1'b1, pred_pan.pos, pred_tilt.pos);
    drain_results();
  endtask

  // Well-formed slews held until stable, with some cut short by a new goal.
  task automatic run_slews(input int budget);
    int   done;
    int   goal_p;
    int   goal_t;
    int   hold;
    int   n;
    logic idle;
    done = 0;
    while (done < budget) begin
      case ($urandom_range(0, 9))
        0: begin
          goal_p = $urandom_range(0, 1) ? PosMax : 0;
          goal_t = $urandom_range(0, 1) ? PosMax : 0;
        end
        1, 2: begin
          goal_p = clamp_pos(pred_pan.pos + int'($urandom_range(0, 40)) - 20);
          goal_t = clamp_pos(pred_tilt.pos + int'($urandom_range(0, 40)) - 20);
        end
        default: begin
          goal_p = $urandom_range(0, PosMax);
          goal_t = $urandom_range(0, PosMax);
        end
      endcase
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : 400;
      n    = 0;
      do begin
        idle = ($urandom_range(0, 9) != 0);
        if (!(pred_phase == PhStable &&
              (!idle || (pred_pan.pos == goal_p && pred_tilt.pos == goal_t))))
          done++;
        send_tick(idle, goal_p, goal_t);
        n++;
      end while (n < hold &&
                 !(pred_phase == PhStable && pred_pan.pos == goal_p &&
                   pred_tilt.pos == goal_t));
    end
  endtask

  task automatic test_random_slews();
    for (int k = 0; k < 6; k++) begin
      drain_results();
      tx_max_gap   = 8;
      rx_max_stall = 8;
      case (k)
        0: begin
          set_profile(1, 1, 3);
          run_slews(400);
        end
        1: begin
          set_profile(15, 15, 0);
          write_reg(RegHomePan, 0);
          write_reg(RegHomeTilt, PosMax);
          run_slews(350);
        end
        2: begin
          // back to back on both sides
          set_profile(0, 9, 5);
          tx_max_gap   = 0;
          rx_max_stall = 0;
          run_slews(300);
        end
        3: begin
          set_profile(7, 0, 65535);
          run_slews(120);
        end
        4: begin
          set_profile(3, 15, 1);
          write_reg(RegHomePan, PosMax);
          write_reg(RegHomeTilt, 0);
          run_slews(300);
        end
        default: begin
          set_profile(15, 1, 2);
          run_slews(200);
        end
      endcase
    end
    drain_results();
    tx_max_gap   = 8;
    rx_max_stall = 8;
  endtask

  task automatic test_backpressure();
    set_profile(4, 4, 2);
    tx_max_gap = 0;
    rx_hold    = HoldCycles;
    // keep offering far goals while the output is held off
    for (int i = 0; i < 16; i++)
      send_tick(1'b1, (i % 2) ? PosMax : 0, (i % 2) ? 0 : PosMax);
    tx_max_gap = 8;
    drain_results();
    repeat (8) send_tick(1'b1, $urandom_range(0, PosMax), $urandom_range(0, PosMax));
    drain_results();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_slews.size() == 0) begin
        report_mismatch("unexpected result, pan_position", m_axis_tdata[FieldBits-1:0], 0);
      end else begin
        due_slew  = expected_slews.pop_front();
        seen_slew = slew_out_t'(m_axis_tdata[OutPayloadBits-1:0]);
        results_checked++;
        if (seen_slew.pan_pos != due_slew.pan_pos)
          report_mismatch("pan_position", seen_slew.pan_pos, due_slew.pan_pos);
        if (seen_slew.tilt_pos != due_slew.tilt_pos)
          report_mismatch("tilt_position", seen_slew.tilt_pos, due_slew.tilt_pos);
        if (seen_slew.pan_vel != due_slew.pan_vel)
          report_mismatch("pan_velocity", $signed(seen_slew.pan_vel),
                          $signed(due_slew.pan_vel));
        if (seen_slew.tilt_vel != due_slew.tilt_vel)
          report_mismatch("tilt_velocity", $signed(seen_slew.tilt_vel),
                          $signed(due_slew.tilt_vel));
        if (seen_slew.stable != due_slew.stable)
          report_mismatch("stable_flag", seen_slew.stable, due_slew.stable);
        if (seen_slew.phase != due_slew.phase)
          report_mismatch("slew_phase", seen_slew.phase, due_slew.phase);
      end
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        repeat (rx_hold) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
        rx_hold = 0;
      end
      stall = $urandom_range(0, rx_max_stall);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    reg_accel_pan  = AccelDefault;
    reg_accel_tilt = AccelDefault;
    reg_settle     = SettleDefault;
    reg_home_pan   = HomeDefault;
    reg_home_tilt  = HomeDefault;
    pred_phase     = PhStable;
    pred_settle    = 0;
    pred_pan.pos   = HomeDefault;
    pred_pan.vel   = 0;
    pred_tilt.pos  = HomeDefault;
    pred_tilt.vel  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_phases();
    test_random_slews();
    test_backpressure();

    drain_results();
    repeat (DrainWait) @(posedge clk_i);
    $display("Checked %0d results from %0d ticks across %0d register writes;",
             results_checked, ticks_accepted, regs_written);
    $display("slews with shutter gating, settle restarts, extreme goals and a held output.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
